FILE: rtl/pfla_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// pfla_pkg
// Shared widths, pool sizes, operation and status codes for the page
// free-list allocator.
// ============================================================================
package pfla_pkg;

    // Pool sizing
    localparam int MAX_PAGES     = 1024;
    localparam int INITIAL_PAGES = 16;

    // Field widths
    localparam int PAGE_W = 10;
    localparam int CNT_W  = 11;

    // Operation codes
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Result status codes
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    // One result item
    typedef struct packed {
        logic [PAGE_W-1:0] page_out;
        status_t           status;
    } result_t;

endpackage

FILE: rtl/pfla_if.sv
`timescale 1ns / 1ps
// ============================================================================
// pfla_req_if / pfla_rsp_if
// Valid/ready channels for allocator requests and results.
// ============================================================================
interface pfla_req_if;
    logic                         valid;
    logic                         ready;
    logic                         kind;
    logic [pfla_pkg::PAGE_W-1:0]  page;

    modport source (output valid, output kind, output page, input ready);
    modport sink   (input valid, input kind, input page, output ready);
endinterface

interface pfla_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [pfla_pkg::PAGE_W-1:0]  page_out;
    logic [1:0]                   status;

    modport source (output valid, output page_out, output status, input ready);
    modport sink   (input valid, input page_out, input status, output ready);
endinterface

FILE: rtl/page_free_list_allocator.sv
`timescale 1ns / 1ps
// ============================================================================
// page_free_list_allocator
// Free-list page allocator with a linked list of free pages kept in a link
// RAM; the pool doubles when the list runs dry.
// ============================================================================
// Usage:
//   req (sink): kind (0 alloc, 1 free) and page; one transfer per request.
//   rsp (source): page_out and status (0 ok, 1 out of range, 2 pool full);
//   exactly one result transfer per request, in request order.
//   Timing: one request in flight at a time.
//     free or pool-full alloc: result registered in the cycle after transfer,
//       next request accepted the following cycle while the skid entry is free.
//     alloc from the list: goes through S_READ, where the registered link RAM
//       read of the head returns and the popped link is cleared.
//     alloc that grows the pool: S_GROW makes one link RAM write per new page
//       on the single write port.
//   Reset: after rst_n releases, an init walk writes links 1..INITIAL_PAGES-1
//   while req.ready stays low. Higher entries are always written by a growth
//   walk before they can be read.
//   Receiver stall: results queue in a two-entry buffer; a new request is
//   taken as long as the skid entry is free.
// ============================================================================
module page_free_list_allocator (
    input  logic       clk,
    input  logic       rst_n,
    pfla_req_if.sink   req,
    pfla_rsp_if.source rsp
);

    localparam int PW = pfla_pkg::PAGE_W;
    localparam int CW = pfla_pkg::CNT_W;

    typedef enum logic [3:0] {
        S_INIT = 4'b0001,
        S_IDLE = 4'b0010,
        S_READ = 4'b0100,
        S_GROW = 4'b1000
    } state_t;

    state_t            state_reg, state_next;
    logic [PW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [PW-1:0]     walk_reg, walk_next;
    logic [PW-1:0]     grow_end_reg, grow_end_next;

    logic              accept;
    logic              space;
    logic              push;
    pfla_pkg::result_t push_data;
    logic              ram_we;
    logic [PW-1:0]     ram_waddr;
    logic [PW-1:0]     ram_wdata;
    logic [PW-1:0]     ram_rdata;
    logic [CW:0]       count_dbl;
    logic              free_ok;

    assign req.ready = (state_reg == S_IDLE) && space;
    assign accept    = req.valid && req.ready;
    assign count_dbl = {count_reg, 1'b0};
    assign free_ok   = (req.page != '0) && ({1'b0, req.page} < count_reg);

    // Control and link RAM write sequencing
    always_comb
    begin
        state_next         = state_reg;
        head_next          = head_reg;
        count_next         = count_reg;
        walk_next          = walk_reg;
        grow_end_next      = grow_end_reg;
        push               = 1'b0;
        push_data.page_out = head_reg;
        push_data.status   = pfla_pkg::STATUS_OK;
        ram_we             = 1'b0;
        ram_waddr          = walk_reg;
        ram_wdata          = '0;
        case (state_reg)
            S_INIT:
            begin
                ram_we = 1'b1;
                if (walk_reg == PW'(pfla_pkg::INITIAL_PAGES - 1))
                begin
                    ram_wdata  = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    ram_wdata = walk_reg + PW'(1);
                end
                walk_next = walk_reg + PW'(1);
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    if (req.kind == pfla_pkg::KIND_FREE)
                    begin
                        push               = 1'b1;
                        push_data.page_out = req.page;
                        if (free_ok)
                        begin
                            ram_we    = 1'b1;
                            ram_waddr = req.page;
                            ram_wdata = head_reg;
                            head_next = req.page;
                        end
                        else
                        begin
                            push_data.status = pfla_pkg::STATUS_RANGE;
                        end
                    end
                    else if (head_reg != '0)
                    begin
                        // link of head is being read this cycle
                        state_next = S_READ;
                    end
                    else if (count_dbl > (CW + 1)'(pfla_pkg::MAX_PAGES))
                    begin
                        push               = 1'b1;
                        push_data.page_out = '0;
                        push_data.status   = pfla_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        walk_next     = count_reg[PW-1:0];
                        grow_end_next = count_dbl[PW-1:0] - PW'(1);
                        state_next    = S_GROW;
                    end
                end
            end
            S_READ:
            begin
                // pop head, clear its link
                push       = 1'b1;
                ram_we     = 1'b1;
                ram_waddr  = head_reg;
                ram_wdata  = '0;
                head_next  = ram_rdata;
                state_next = S_IDLE;
            end
            S_GROW:
            begin
                // chain new pages; first (returned) and last links are 0
                ram_we = 1'b1;
                if ((walk_reg == count_reg[PW-1:0]) || (walk_reg == grow_end_reg))
                begin
                    ram_wdata = '0;
                end
                else
                begin
                    ram_wdata = walk_reg + PW'(1);
                end
                walk_next = walk_reg + PW'(1);
                if (walk_reg == grow_end_reg)
                begin
                    push               = 1'b1;
                    push_data.page_out = count_reg[PW-1:0];
                    head_next          = count_reg[PW-1:0] + PW'(1);
                    count_next         = count_dbl[CW-1:0];
                    state_next         = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            head_reg  <= PW'(1);
            count_reg <= CW'(pfla_pkg::INITIAL_PAGES);
            walk_reg  <= PW'(1);
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            count_reg <= count_next;
            walk_reg  <= walk_next;
        end
    end

    always_ff @(posedge clk)
    begin
        grow_end_reg <= grow_end_next;
    end

    // Link RAM
    pfla_ram #(
        .WIDTH (PW),
        .DEPTH (pfla_pkg::MAX_PAGES)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    // Result buffer
    pfla_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .space     (space),
        .rsp       (rsp)
    );

    // Checks
    a_ready_idle_only: assert property (@(posedge clk) disable iff (!rst_n)
        req.ready |-> (state_reg == S_IDLE))
        else $error("request taken outside idle state");

    a_read_follows_alloc: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_READ) |-> $past(accept && (req.kind == pfla_pkg::KIND_ALLOC)))
        else $error("link read state without an alloc transfer");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(pfla_pkg::MAX_PAGES))
        else $error("page count exceeds pool capacity");

    a_head_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> ({1'b0, head_reg} < count_reg))
        else $error("list head outside the pool");

endmodule

FILE: rtl/pfla_ram.sv
`timescale 1ns / 1ps
// ============================================================================
// pfla_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ============================================================================
module pfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/pfla_out_buf.sv
`timescale 1ns / 1ps
// ============================================================================
// pfla_out_buf
// Two-deep result buffer: an output register plus a skid register, so the
// controller can take a new request while a result waits for the receiver.
// ============================================================================
module pfla_out_buf (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  pfla_pkg::result_t push_data,
    output logic              space,
    pfla_rsp_if.source        rsp
);

    logic              out_valid_reg, out_valid_next;
    logic              skid_valid_reg, skid_valid_next;
    pfla_pkg::result_t out_data_reg, out_data_next;
    pfla_pkg::result_t skid_data_reg, skid_data_next;
    logic              pop;

    assign pop   = out_valid_reg && rsp.ready;
    assign space = !skid_valid_reg;

    // Slot management
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (pop)
        begin
            out_valid_next = skid_valid_reg;
            out_data_next  = skid_data_reg;
            skid_valid_next = 1'b0;
        end
        if (push)
        begin
            if (!out_valid_next)
            begin
                out_valid_next = 1'b1;
                out_data_next  = push_data;
            end
            else
            begin
                skid_valid_next = 1'b1;
                skid_data_next  = push_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.page_out = out_data_reg.page_out;
    assign rsp.status   = out_data_reg.status;

    // Checks
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot holds a result while output slot is empty");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !skid_valid_reg)
        else $error("result pushed into a full buffer");

    a_skid_moves_up: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && skid_valid_reg) |=> out_valid_reg)
        else $error("skid result lost on output transfer");

endmodule
